>>> rtl/row_extremum_lsb_embed_core_defines.svh
// Assertion macros for the row extremum LSB embed core.
// Included by modules that check their own logic; no other dependencies.
`ifndef ROW_EXTREMUM_LSB_EMBED_CORE_DEFINES_SVH
`define ROW_EXTREMUM_LSB_EMBED_CORE_DEFINES_SVH

`ifndef SYNTH
`define RELB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
`define RELB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define RELB_ASSERT(lbl, expr)
`define RELB_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

>>> rtl/relb_pkg.sv
// Shared types and constants for the row extremum LSB embed core.
// No dependencies.
package relb_pkg;

  localparam int HEADER_BITS_DEF = 32;
  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int COL_W = 12;
  localparam int IDX_W = 40;
  localparam int LEN_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PUSH  = 1'b1;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic PICK_MAX = 1'b0;
  localparam logic PICK_MIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [7:0]       new_blue;
    logic             embedded;
    logic             starved;
    logic             bit_read;
    logic [7:0]       byte_out;
    logic             byte_valid;
    logic [LEN_W-1:0] decoded_length;
  } res_t;

endpackage

>>> rtl/row_extremum_lsb_embed_core.sv
// Top level of the row extremum LSB embed core.
// Depends on relb_pkg and row_extremum_lsb_embed_core_defines.svh.

// Takes one item per clock, pixels and payload bytes alike, with no bubbles while not stalled.
// A row-end pixel's result is registered into an output register backed by a
// one-entry skid buffer; the input stalls only while that skid entry is occupied.
// Payload bytes live in a synchronous memory used as a circular queue; the head
// byte is prefetched into a register (with write forwarding into an empty queue),
// so the per-row bit pick and the running red extremum compare are both
// combinational.
// No clearing pass is needed after reset.
`include "row_extremum_lsb_embed_core_defines.svh"

module row_extremum_lsb_embed_core #(
  parameter int HEADER_BITS = relb_pkg::HEADER_BITS_DEF,
  parameter int MAX_COLUMNS = relb_pkg::MAX_COLUMNS_DEF,
  parameter int QUEUE_DEPTH = relb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [relb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [relb_pkg::LEN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_blue,
  input  logic                          in_frame_start,
  input  logic                          in_row_end,
  input  logic [7:0]                    in_payload_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [relb_pkg::COL_W-1:0]    out_column,
  output logic [7:0]                    out_new_blue,
  output logic                          out_embedded,
  output logic                          out_starved,
  output logic                          out_bit_read,
  output logic [7:0]                    out_byte_out,
  output logic                          out_byte_valid,
  output logic [relb_pkg::LEN_W-1:0]    out_decoded_length
);

  localparam int CC_W = $clog2(MAX_COLUMNS + 1);
  localparam int BC_W = $clog2(MAX_COLUMNS);
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = relb_pkg::IDX_W;
  localparam int LEN_W = relb_pkg::LEN_W;

  // configuration
  logic             mode_r;
  logic             pick_r;
  logic [LEN_W-1:0] msg_len_r;

  // row and frame state
  logic [7:0]       best_red_r,  best_red_nxt;
  logic [7:0]       best_blue_r, best_blue_nxt;
  logic [BC_W-1:0]  best_col_r,  best_col_nxt;
  logic [CC_W-1:0]  col_cnt_r,   col_cnt_nxt;
  logic [IDX_W-1:0] bit_idx_r,   bit_idx_nxt;
  logic [LEN_W-1:0] len_shift_r, len_shift_nxt;
  logic [7:0]       byte_shift_r, byte_shift_nxt;

  // payload queue
  logic [7:0]       q_mem [QUEUE_DEPTH];
  logic [QA_W-1:0]  q_head_r, q_head_nxt;
  logic [QA_W-1:0]  q_tail_r, q_tail_nxt;
  logic [QC_W-1:0]  q_count_r, q_count_nxt;
  logic [7:0]       head_byte_r;
  logic             q_push, q_pop;

  // output register and skid
  logic             out_valid_r, out_valid_nxt;
  relb_pkg::res_t   out_r, out_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  relb_pkg::res_t   skid_r, skid_nxt;

  logic             in_fire, pix_fire, res_fire, out_free;
  relb_pkg::res_t   res;

  // per-item datapath
  logic [CC_W-1:0]  cc_eff;
  logic [IDX_W-1:0] k_eff;
  logic [LEN_W-1:0] len_eff;
  logic [7:0]       bsh_eff;
  logic             in_range, take, upd;
  logic [7:0]       sel_blue;
  logic [BC_W-1:0]  sel_col;
  logic             in_hdr;
  logic [6:0]       hdr_j;
  logic             hdr_bit;
  logic [IDX_W-1:0] pay_p;
  logic [IDX_W-4:0] byte_no;
  logic [2:0]       pos;
  logic             byte_due_emb, byte_due_ext;
  logic             pay_bit;
  logic             bit_rd;
  logic             bump;
  logic [IDX_W-1:0] k_inc;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign pix_fire = in_fire && (in_op == relb_pkg::OP_PIXEL);
  assign res_fire = pix_fire && in_row_end;
  assign out_free = !out_valid_r || !out_stall;

  assign cc_eff  = in_frame_start ? '0 : col_cnt_r;
  assign k_eff   = in_frame_start ? '0 : bit_idx_r;
  assign len_eff = in_frame_start ? '0 : len_shift_r;
  assign bsh_eff = in_frame_start ? '0 : byte_shift_r;

  assign in_range = cc_eff < CC_W'(MAX_COLUMNS);

  always_comb begin
    if (cc_eff == '0) begin
      take = 1'b1;
    end else if (pick_r == relb_pkg::PICK_MAX) begin
      take = in_red > best_red_r;
    end else begin
      take = in_red < best_red_r;
    end
  end

  assign upd      = in_range && take;
  assign sel_blue = upd ? in_blue : best_blue_r;
  assign sel_col  = upd ? BC_W'(cc_eff) : best_col_r;

  assign in_hdr  = k_eff < IDX_W'(HEADER_BITS);
  assign hdr_j   = 7'(HEADER_BITS - 1) - k_eff[6:0];
  assign hdr_bit = (hdr_j < 7'd32) ? msg_len_r[hdr_j[4:0]] : 1'b0;
  assign pay_p   = k_eff - IDX_W'(HEADER_BITS);
  assign byte_no = pay_p[IDX_W-1:3];
  assign pos     = pay_p[2:0];
  assign pay_bit = head_byte_r[3'd7 - pos];
  assign bit_rd  = sel_blue[0];

  assign byte_due_emb = {3'b000, byte_no} < {{(IDX_W - LEN_W){1'b0}}, msg_len_r};
  assign byte_due_ext = {3'b000, byte_no} < {{(IDX_W - LEN_W){1'b0}}, len_eff};

  assign k_inc = (k_eff == {IDX_W{1'b1}}) ? k_eff : k_eff + IDX_W'(1);

  always_comb begin
    res            = '0;
    res.column     = relb_pkg::COL_W'(sel_col);
    res.new_blue   = sel_blue;
    bump           = 1'b0;
    q_pop          = 1'b0;
    len_shift_nxt  = len_eff;
    byte_shift_nxt = bsh_eff;
    if (mode_r == relb_pkg::MODE_EMBED) begin
      if (in_hdr) begin
        res.new_blue = {sel_blue[7:1], hdr_bit};
        res.embedded = 1'b1;
        bump         = 1'b1;
      end else if (byte_due_emb) begin
        if (q_count_r == '0) begin
          res.starved = 1'b1;
        end else begin
          res.new_blue = {sel_blue[7:1], pay_bit};
          res.embedded = 1'b1;
          bump         = 1'b1;
          q_pop        = res_fire && (pos == 3'd7);
        end
      end
    end else begin
      res.bit_read = bit_rd;
      bump         = 1'b1;
      if (in_hdr) begin
        len_shift_nxt = {len_eff[LEN_W-2:0], bit_rd};
      end else begin
        byte_shift_nxt = {bsh_eff[6:0], bit_rd};
        if (pos == 3'd7 && byte_due_ext) begin
          res.byte_out   = byte_shift_nxt;
          res.byte_valid = 1'b1;
        end
      end
      res.decoded_length = len_shift_nxt;
    end
  end

  always_comb begin
    best_red_nxt  = best_red_r;
    best_blue_nxt = best_blue_r;
    best_col_nxt  = best_col_r;
    col_cnt_nxt   = col_cnt_r;
    bit_idx_nxt   = bit_idx_r;
    if (pix_fire) begin
      if (upd) begin
        best_red_nxt  = in_red;
        best_blue_nxt = in_blue;
        best_col_nxt  = BC_W'(cc_eff);
      end
      if (in_row_end) begin
        col_cnt_nxt = '0;
        bit_idx_nxt = bump ? k_inc : k_eff;
      end else begin
        col_cnt_nxt = in_range ? cc_eff + CC_W'(1) : cc_eff;
        bit_idx_nxt = k_eff;
      end
    end
  end

  // queue pointers
  assign q_push = in_fire && (in_op == relb_pkg::OP_PUSH) &&
                  (q_count_r < QC_W'(QUEUE_DEPTH));

  always_comb begin
    q_head_nxt  = q_head_r;
    q_tail_nxt  = q_tail_r;
    q_count_nxt = q_count_r;
    if (q_push) begin
      q_tail_nxt  = (q_tail_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + QA_W'(1);
      q_count_nxt = q_count_r + QC_W'(1);
    end
    if (q_pop) begin
      q_head_nxt  = (q_head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + QA_W'(1);
      q_count_nxt = q_count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_tail_r] <= in_payload_byte;
    end
  end

  // prefetch the head byte; forward a push that lands on the head entry
  always_ff @(posedge clk) begin
    if (q_push && (q_tail_r == q_head_nxt)) begin
      head_byte_r <= in_payload_byte;
    end else begin
      head_byte_r <= q_mem[q_head_nxt];
    end
  end

  // output register and skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_fire;
        out_nxt       = res;
      end
    end else if (res_fire) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= relb_pkg::MODE_EMBED;
      pick_r       <= relb_pkg::PICK_MAX;
      msg_len_r    <= '0;
      best_red_r   <= '0;
      best_blue_r  <= '0;
      best_col_r   <= '0;
      col_cnt_r    <= '0;
      bit_idx_r    <= '0;
      len_shift_r  <= '0;
      byte_shift_r <= '0;
      q_head_r     <= '0;
      q_tail_r     <= '0;
      q_count_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          relb_pkg::REG_MODE:   mode_r    <= cfg_data[0];
          relb_pkg::REG_PICK:   pick_r    <= cfg_data[0];
          relb_pkg::REG_LENGTH: msg_len_r <= cfg_data;
          default: ;
        endcase
      end
      best_red_r   <= best_red_nxt;
      best_blue_r  <= best_blue_nxt;
      best_col_r   <= best_col_nxt;
      col_cnt_r    <= col_cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
      if (pix_fire && in_row_end) begin
        len_shift_r  <= len_shift_nxt;
        byte_shift_r <= byte_shift_nxt;
      end else if (pix_fire && in_frame_start) begin
        len_shift_r  <= '0;
        byte_shift_r <= '0;
      end
      q_head_r     <= q_head_nxt;
      q_tail_r     <= q_tail_nxt;
      q_count_r    <= q_count_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_column         = out_r.column;
  assign out_new_blue       = out_r.new_blue;
  assign out_embedded       = out_r.embedded;
  assign out_starved        = out_r.starved;
  assign out_bit_read       = out_r.bit_read;
  assign out_byte_out       = out_r.byte_out;
  assign out_byte_valid     = out_r.byte_valid;
  assign out_decoded_length = out_r.decoded_length;

  `RELB_ASSERT(a_q_count_bound, q_count_r <= QC_W'(QUEUE_DEPTH))
  `RELB_ASSERT(a_col_cnt_bound, col_cnt_r <= CC_W'(MAX_COLUMNS))
  `RELB_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r)
  `RELB_ASSERT_IMP(a_pop_nonempty, q_pop, q_count_r != '0)
  `RELB_ASSERT_IMP(a_empty_ptrs, q_count_r == '0, q_head_r == q_tail_r)

endmodule

>>> test/relb_scoreboard.sv
// Result checker for row_extremum_lsb_embed_core: tracks register writes and input
// transfers, predicts each row result and compares the result channel field by field.
// Depends on relb_pkg.
module relb_scoreboard
  import relb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_op,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_blue,
  input  logic             in_frame_start,
  input  logic             in_row_end,
  input  logic [7:0]       in_payload_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [COL_W-1:0] out_column,
  input  logic [7:0]       out_new_blue,
  input  logic             out_embedded,
  input  logic             out_starved,
  input  logic             out_bit_read,
  input  logic [7:0]       out_byte_out,
  input  logic             out_byte_valid,
  input  logic [LEN_W-1:0] out_decoded_length,
  output int               errors,
  output int               pending,
  output int               rows_checked,
  output int               bytes_found,
  output int               starved_rows
);

  logic             cur_mode;
  logic             cur_pick;
  logic [LEN_W-1:0] msg_len;

  logic [7:0]       best_red;
  logic [COL_W-1:0] best_col;
  logic [7:0]       best_blue;
  int               col_cnt;
  logic [IDX_W-1:0] row_idx;
  logic [LEN_W-1:0] len_acc;
  logic [7:0]       byte_acc;
  logic [7:0]       byte_fifo[$];
  res_t             rows_due[$];

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void advance_row_index();
    if (row_idx != {IDX_W{1'b1}}) row_idx++;
  endfunction

  task automatic predict_row_result(input logic op, input logic [7:0] red,
                                    input logic [7:0] blue, input logic fs,
                                    input logic re, input logic [7:0] pb);
    res_t r;
    logic take;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] p;
    if (op == OP_PUSH) begin
      if (byte_fifo.size() < QUEUE_DEPTH_DEF) byte_fifo.push_back(pb);
      return;
    end
    if (fs) begin
      row_idx = '0;
      len_acc = '0;
      byte_acc = '0;
      col_cnt = 0;
    end
    if (col_cnt < MAX_COLUMNS_DEF) begin
      if (col_cnt == 0) take = 1'b1;
      else if (cur_pick == PICK_MAX) take = red > best_red;
      else take = red < best_red;
      if (take) begin
        best_red = red;
        best_blue = blue;
        best_col = COL_W'(col_cnt);
      end
      col_cnt++;
    end
    if (!re) return;
    col_cnt = 0;
    k = row_idx;
    r = '0;
    r.column = best_col;
    r.new_blue = best_blue;
    if (cur_mode == MODE_EMBED) begin
      if (k < HEADER_BITS_DEF) begin
        r.new_blue[0] = msg_len[5'd31 - k[4:0]];
        r.embedded = 1'b1;
        advance_row_index();
      end else begin
        p = k - HEADER_BITS_DEF;
        if ((p >> 3) < msg_len) begin
          if (byte_fifo.size() == 0) begin
            r.starved = 1'b1;
          end else begin
            r.new_blue[0] = byte_fifo[0][3'd7 - p[2:0]];
            r.embedded = 1'b1;
            if (p[2:0] == 3'd7) void'(byte_fifo.pop_front());
            advance_row_index();
          end
        end
      end
    end else begin
      r.bit_read = best_blue[0];
      if (k < HEADER_BITS_DEF) begin
        len_acc = {len_acc[LEN_W-2:0], r.bit_read};
      end else begin
        p = k - HEADER_BITS_DEF;
        byte_acc = {byte_acc[6:0], r.bit_read};
        if (p[2:0] == 3'd7 && (p >> 3) < len_acc) begin
          r.byte_out = byte_acc;
          r.byte_valid = 1'b1;
        end
      end
      r.decoded_length = len_acc;
      advance_row_index();
    end
    rows_due.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      cur_mode = MODE_EMBED;
      cur_pick = PICK_MAX;
      msg_len = '0;
      best_red = '0;
      best_col = '0;
      best_blue = '0;
      col_cnt = 0;
      row_idx = '0;
      len_acc = '0;
      byte_acc = '0;
      byte_fifo.delete();
      rows_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          $error("row result transfer with no result due");
          errors++;
        end else begin
          want = rows_due.pop_front();
          check_field("column", 32'(want.column), 32'(out_column));
          check_field("new_blue", 32'(want.new_blue), 32'(out_new_blue));
          check_field("embedded", 32'(want.embedded), 32'(out_embedded));
          check_field("starved", 32'(want.starved), 32'(out_starved));
          check_field("bit_read", 32'(want.bit_read), 32'(out_bit_read));
          check_field("byte_out", 32'(want.byte_out), 32'(out_byte_out));
          check_field("byte_valid", 32'(want.byte_valid), 32'(out_byte_valid));
          check_field("decoded_length", 32'(want.decoded_length), 32'(out_decoded_length));
          rows_checked++;
          if (want.byte_valid) bytes_found++;
          if (want.starved) starved_rows++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   cur_mode = cfg_data[0];
          REG_PICK:   cur_pick = cfg_data[0];
          REG_LENGTH: msg_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_row_result(in_op, in_red, in_blue, in_frame_start, in_row_end,
                           in_payload_byte);
    end
    pending = rows_due.size();
  end

endmodule

>>> test/tb_row_extremum_lsb_embed_core.sv
// Testbench top for row_extremum_lsb_embed_core: drives directed and random pixel
// and payload traffic under several idle and stall mixes and reports the verdict.
// Depends on relb_pkg, the core and relb_scoreboard.
module tb_row_extremum_lsb_embed_core;
  import relb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_RUN = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_PIXEL;
  logic [7:0] in_red = '0;
  logic [7:0] in_blue = '0;
  logic in_frame_start = 1'b0;
  logic in_row_end = 1'b0;
  logic [7:0] in_payload_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COL_W-1:0] out_column;
  logic [7:0] out_new_blue;
  logic out_embedded;
  logic out_starved;
  logic out_bit_read;
  logic [7:0] out_byte_out;
  logic out_byte_valid;
  logic [LEN_W-1:0] out_decoded_length;

  int errors;
  int pending;
  int rows_checked;
  int bytes_found;
  int starved_rows;

  int idle_pct = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int quiet_cycles = 0;
  int transfers_in = 0;

  row_extremum_lsb_embed_core DUT (.*);

  relb_scoreboard u_score (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    if (stall_run >= MAX_RUN || $urandom_range(0, 99) >= stall_pct) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else begin
      out_stall <= 1'b1;
      stall_run <= stall_run + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic transfer(input logic op, input logic [7:0] red, input logic [7:0] blue,
                          input logic fs, input logic re, input logic [7:0] pb);
    int gap;
    @(negedge clk);
    gap = 0;
    while (gap < MAX_RUN && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      gap++;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_red <= red;
    in_blue <= blue;
    in_frame_start <= fs;
    in_row_end <= re;
    in_payload_byte <= pb;
    do @(posedge clk); while (in_stall);
    transfers_in++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    transfer(OP_PUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), b);
  endtask

  task automatic pixel(input logic [7:0] red, input logic [7:0] blue,
                       input logic fs, input logic re);
    transfer(OP_PIXEL, red, blue, fs, re, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender until every due row result has been taken
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle;
    drain;
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_red();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(100, 102));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input bit encoded, input logic [31:0] hdr_len,
                            input int rows, input int max_w, input int push_pct);
    int w;
    logic lsb;
    logic [7:0] b;
    logic fs;
    for (int r = 0; r < rows; r++) begin
      lsb = (r < 32) ? hdr_len[31 - r] : 1'($urandom_range(0, 1));
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, max_w);
      if ($urandom_range(0, 29) == 0) drain;
      for (int c = 0; c < w; c++) begin
        while ($urandom_range(0, 99) < push_pct) push_byte(8'($urandom_range(0, 255)));
        b = 8'($urandom_range(0, 255));
        if (encoded) b[0] = lsb;
        fs = (r == 0 && c == 0) || (!encoded && $urandom_range(0, 199) == 0);
        pixel(pick_red(), b, fs, c == w - 1);
      end
    end
  endtask

  initial begin
    logic s_mode;
    logic s_pick;
    logic [31:0] s_len;
    bit s_encoded;
    int start;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_MODE, {31'($urandom), MODE_EMBED});
    cfg_write(REG_PICK, {31'($urandom), PICK_MAX});
    cfg_write(REG_LENGTH, 32'hA5A5_0001);
    cfg_write(REG_SPARE, $urandom);
    push_byte(8'h00);
    push_byte(8'hFF);
    pixel(8'd0, 8'hFF, 1'b1, 1'b0);
    pixel(8'd255, 8'h00, 1'b0, 1'b0);
    pixel(8'd255, 8'h01, 1'b0, 1'b0);
    pixel(8'd254, 8'h80, 1'b0, 1'b1);
    pixel(8'd255, 8'hFF, 1'b0, 1'b1);
    pixel(8'd0, 8'h00, 1'b0, 1'b0);
    pixel(8'd0, 8'h01, 1'b0, 1'b1);
    settle;
    cfg_write(REG_PICK, LEN_W'(PICK_MIN));
    pixel(8'd255, 8'h00, 1'b1, 1'b0);
    pixel(8'd0, 8'h03, 1'b0, 1'b0);
    pixel(8'd0, 8'h02, 1'b0, 1'b1);
    pixel(8'd0, 8'h00, 1'b0, 1'b1);
    settle;
    cfg_write(REG_MODE, LEN_W'(MODE_EXTRACT));
    cfg_write(REG_PICK, LEN_W'(PICK_MAX));
    pixel(8'd7, 8'h01, 1'b1, 1'b1);
    pixel(8'd7, 8'h00, 1'b0, 1'b1);
    // overlong row: the larger reds past the column limit must not win
    for (int c = 0; c < MAX_COLUMNS_DEF + 4; c++)
      pixel((c < MAX_COLUMNS_DEF) ? 8'(c % 100) : 8'd255, 8'($urandom_range(0, 255)),
            1'b0, c == MAX_COLUMNS_DEF + 3);

    for (int s = 0; s < 8; s++) begin
      case (s / 2)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 66; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 66; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      s_encoded = 1'b0;
      case (s)
        0: begin s_mode = MODE_EMBED; s_pick = PICK_MAX; s_len = 32'd0; end
        1: begin s_mode = MODE_EMBED; s_pick = PICK_MIN; s_len = 32'd2; end
        2: begin s_mode = MODE_EXTRACT; s_pick = PICK_MAX; s_encoded = 1'b1; end
        3: begin s_mode = MODE_EMBED; s_pick = PICK_MAX; s_len = 32'hFFFF_FFFF; end
        4: begin s_mode = MODE_EXTRACT; s_pick = PICK_MIN; end
        5: begin s_mode = MODE_EMBED; s_pick = PICK_MIN; s_len = 32'd3; end
        6: begin s_mode = MODE_EXTRACT; s_pick = PICK_MAX; s_encoded = 1'b1; end
        default: begin s_mode = MODE_EMBED; s_pick = PICK_MAX; s_len = 32'd1; end
      endcase
      if (s_mode == MODE_EXTRACT) s_len = $urandom;
      settle;
      cfg_write(REG_MODE, {31'($urandom), s_mode});
      cfg_write(REG_PICK, {31'($urandom), s_pick});
      cfg_write(REG_LENGTH, s_len);
      start = transfers_in;
      while (transfers_in - start < 165) begin
        if (s_mode == MODE_EMBED)
          repeat ($urandom_range(0, 20)) push_byte(8'($urandom_range(0, 255)));
        send_frame(s_encoded, $urandom_range(0, 3), $urandom_range(34, 60), 4,
                   (s_mode == MODE_EMBED) ? 15 : 5);
      end
    end

    drain;
    repeat (8) @(negedge clk);
    $display("covered %0d input transfers across eight register settings and four idle mixes",
             transfers_in);
    $display("%0d row results checked, %0d payload bytes extracted, %0d starved rows",
             rows_checked, bytes_found, starved_rows);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
